// ===== rtl/line_sensor_centroid_top_defines.svh =====
`ifndef LINE_SENSOR_CENTROID_TOP_DEFINES_SVH
`define LINE_SENSOR_CENTROID_TOP_DEFINES_SVH

// same-cycle implication
`define LSC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lsc assertion failed");

// next-cycle implication
`define LSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lsc assertion failed");

`endif

// ===== rtl/lsc_pkg.sv =====
`default_nettype none

package lsc_pkg;

  localparam int NUM_SENSORS  = 5;
  localparam int SAMPLE_BITS  = 8;
  localparam int SPACING_BITS = 12;
  localparam int OFFSET_BITS  = 14;
  localparam int POS_BITS     = 15;
  localparam int POS_MAX      = 16383;
  localparam int POS_MIN      = -16384;

  localparam int CFG_DATA_BITS  = OFFSET_BITS;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_SENSOR_SPACING = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTRE_OFFSET  = 2'd1;

  localparam logic [SPACING_BITS-1:0] SPACING_RESET = 12'd1000;
  localparam logic [OFFSET_BITS-1:0]  OFFSET_RESET  = 14'd2000;

  localparam int QUEUE_DEPTH = 2;

  localparam int SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;
  localparam int KSUM_MAX   = SAMPLE_MAX * (NUM_SENSORS * (NUM_SENSORS - 1) / 2);
  localparam int KSUM_BITS  = $clog2(KSUM_MAX + 1);
  localparam int PSUM_BITS  = $clog2(SAMPLE_MAX * NUM_SENSORS + 1);
  localparam int QBITS      = $clog2((NUM_SENSORS - 1) * ((1 << SPACING_BITS) - 1) + 1);
  localparam int W_BITS     = KSUM_BITS + SPACING_BITS;
  localparam int CMP_BITS   = (W_BITS > PSUM_BITS + QBITS) ? W_BITS : PSUM_BITS + QBITS;
  localparam int DIFF_BASE  = (QBITS > OFFSET_BITS) ? QBITS : OFFSET_BITS;
  localparam int DIFF_BITS  = ((DIFF_BASE > POS_BITS - 1) ? DIFF_BASE : POS_BITS - 1) + 1;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_0;
    logic [SAMPLE_BITS-1:0] sample_1;
    logic [SAMPLE_BITS-1:0] sample_2;
    logic [SAMPLE_BITS-1:0] sample_3;
    logic [SAMPLE_BITS-1:0] sample_4;
  } lsc_in_t;

  typedef struct packed {
    logic signed [POS_BITS-1:0] track_pos;
    logic                       no_line;
  } lsc_out_t;

  typedef struct packed {
    logic [KSUM_BITS-1:0] ksum;
    logic [PSUM_BITS-1:0] psum;
    logic                 zero;
  } lsc_item_t;

  typedef struct packed {
    logic [SPACING_BITS-1:0] spacing;
    logic [OFFSET_BITS-1:0]  offset;
  } lsc_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/lsc_front.sv =====
`default_nettype none

module lsc_front
  import lsc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire lsc_in_t   in_data_i,
  output logic           push_o,
  output lsc_item_t      item_o,
  input  wire logic      full_i
);

  logic [SAMPLE_BITS-1:0] samples [NUM_SENSORS];
  logic                   valid_q, valid_d;
  lsc_item_t              item_q, item_d;

  always_comb begin
    samples[0] = in_data_i.sample_0;
    samples[1] = in_data_i.sample_1;
    samples[2] = in_data_i.sample_2;
    samples[3] = in_data_i.sample_3;
    samples[4] = in_data_i.sample_4;
  end

  // weighted and plain sums, zero-sum classification
  always_comb begin
    item_d.ksum = '0;
    item_d.psum = '0;
    for (int k = 0; k < NUM_SENSORS; k++) begin
      item_d.ksum = item_d.ksum + KSUM_BITS'(k) * KSUM_BITS'(samples[k]);
      item_d.psum = item_d.psum + PSUM_BITS'(samples[k]);
    end
    item_d.zero = (item_d.psum == '0);
  end

  assign push_o     = valid_q && !full_i;
  assign in_ready_o = !valid_q || !full_i;
  assign item_o     = item_q;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lsc_fifo.sv =====
`default_nettype none

`include "line_sensor_centroid_top_defines.svh"

module lsc_fifo
  import lsc_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire lsc_item_t item_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output lsc_item_t      item_o,
  output logic           empty_o
);

  localparam int PtrBits   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CountBits = $clog2(Depth + 1);

  lsc_item_t            mem_q [Depth];
  logic [PtrBits-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CountBits-1:0] count_q, count_d;

  assign full_o  = (count_q == CountBits'(Depth));
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  `LSC_ASSERT_IMPLIES(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CountBits'(Depth))
  `LSC_ASSERT_NEXT(a_count_grows, clk_i, rst_ni, push_i && !pop_i, count_q == $past(count_q) + 1'b1)

endmodule

`default_nettype wire

// ===== rtl/lsc_back.sv =====
`default_nettype none

`include "line_sensor_centroid_top_defines.svh"

module lsc_back
  import lsc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      empty_i,
  output logic           pop_o,
  input  wire lsc_item_t item_i,
  input  wire lsc_cfg_t  cfg_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output lsc_out_t       out_data_o
);

  localparam logic signed [DIFF_BITS-1:0] DiffMax = DIFF_BITS'(POS_MAX);
  localparam logic signed [DIFF_BITS-1:0] DiffMin = DIFF_BITS'(POS_MIN);

  logic                 en;
  logic                 v_q   [QBITS+1];
  logic [W_BITS-1:0]    rem_q [QBITS+1];
  logic [PSUM_BITS-1:0] s_q   [QBITS+1];
  logic [QBITS-1:0]     quo_q [QBITS+1];
  logic                 z_q   [QBITS+1];

  logic [W_BITS-1:0]    rem_d [QBITS+1];
  logic [QBITS-1:0]     quo_d [QBITS+1];

  logic                        out_valid_q;
  lsc_out_t                    out_q, out_d;
  logic signed [DIFF_BITS-1:0] diff;

  assign en          = !out_valid_q || out_ready_i;
  assign pop_o       = en && !empty_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // multiply stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en) begin
      v_q[0] <= pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem_q[0] <= W_BITS'(item_i.ksum) * W_BITS'(cfg_i.spacing);
      s_q[0]   <= item_i.psum;
      z_q[0]   <= item_i.zero;
      quo_q[0] <= '0;
    end
  end

  assign rem_d[0] = '0;
  assign quo_d[0] = '0;

  // restoring divider, one quotient bit per stage, msb first
  for (genvar j = 0; j < QBITS; j++) begin : g_div
    localparam int B = QBITS - 1 - j;
    logic [CMP_BITS-1:0] divisor;
    logic [CMP_BITS-1:0] rem_ext;
    logic                ge;

    always_comb begin
      divisor = CMP_BITS'(s_q[j]) << B;
      rem_ext = CMP_BITS'(rem_q[j]);
      ge      = (rem_ext >= divisor);
      rem_d[j+1] = ge ? W_BITS'(rem_ext - divisor) : rem_q[j];
      quo_d[j+1] = quo_q[j] | (QBITS'(ge) << B);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j+1] <= 1'b0;
      end else if (en) begin
        v_q[j+1] <= v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[j+1] <= rem_d[j+1];
        quo_q[j+1] <= quo_d[j+1];
        s_q[j+1]   <= s_q[j];
        z_q[j+1]   <= z_q[j];
      end
    end
  end

  // offset subtract and saturation
  always_comb begin
    diff = signed'(DIFF_BITS'(quo_q[QBITS])) - signed'(DIFF_BITS'(cfg_i.offset));
    out_d.no_line = z_q[QBITS];
    if (z_q[QBITS]) begin
      out_d.track_pos = '0;
    end else if (diff > DiffMax) begin
      out_d.track_pos = POS_BITS'(DiffMax);
    end else if (diff < DiffMin) begin
      out_d.track_pos = POS_BITS'(DiffMin);
    end else begin
      out_d.track_pos = diff[POS_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v_q[QBITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  `LSC_ASSERT_IMPLIES(a_dark_zero, clk_i, rst_ni, out_valid_q && out_q.no_line, out_q.track_pos == '0)

endmodule

`default_nettype wire

// ===== rtl/line_sensor_centroid_top.sv =====
// line position from a five-sensor reflectance bar
//
// input channel: in_valid_i / in_ready_o carry one transaction of five
// unsigned samples in in_data_i. output channel: out_valid_o / out_ready_i
// carry the signed line position and the no-line flag in out_data_o.
// config: cfg_we_i writes cfg_wdata_i into the register at cfg_index_i
// (0 sensor spacing, 1 centre offset) in the same edge; other indexes are
// ignored. write config only while no transaction is in flight.
// path from input acceptance to out_valid_o: sum register, queue, multiply,
// 14 divider stages and the output register.
// throughput: one transaction per cycle unless the back pipeline stalls,
// set by the divider pipeline that resolves one quotient bit per stage.
// reset: spacing 1000, centre offset 2000, queue and pipeline empty.
// stall: out_ready_i low with out_valid_o high holds the back pipeline;
// queue then fills; in_ready_o drops once sum register and queue are full.
`default_nettype none

module line_sensor_centroid_top
  import lsc_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire lsc_in_t                   in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output lsc_out_t                       out_data_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index_i,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_wdata_i
);

  lsc_cfg_t  cfg_q, cfg_d;
  logic      push, full, pop, empty;
  lsc_item_t front_item, queue_item;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SENSOR_SPACING: cfg_d.spacing = cfg_wdata_i[SPACING_BITS-1:0];
        CFG_CENTRE_OFFSET:  cfg_d.offset  = cfg_wdata_i[OFFSET_BITS-1:0];
        default:            cfg_d         = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spacing <= SPACING_RESET;
      cfg_q.offset  <= OFFSET_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  lsc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .item_o     (front_item),
    .full_i     (full)
  );

  lsc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (queue_item),
    .empty_o (empty)
  );

  lsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_o       (pop),
    .item_i      (queue_item),
    .cfg_i       (cfg_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
